### rtl/cpu_utilization_from_tick_counters_macros.svh
// Assertion macros used by the top-level RTL file to check itself.
`ifndef CPU_UTILIZATION_FROM_TICK_COUNTERS_MACROS_SVH
`define CPU_UTILIZATION_FROM_TICK_COUNTERS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPUU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPUU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cpuu_pkg.sv
// Shared constants and types for the tick-counter utilization meter.
package cpuu_pkg;

    localparam int MAX_CORES   = 16;
    localparam int ENTRY_COUNT = MAX_CORES + 1;
    localparam int IDX_W       = 5;
    localparam int ENTRY_AW    = $clog2(ENTRY_COUNT);
    localparam int TICK_W      = 64;
    localparam int PCT_W       = 15;
    localparam int COUNTER_NUM = 8;
    localparam int SEL_W       = $clog2(COUNTER_NUM);
    // quotient never exceeds full scale, so 15 quotient bits suffice
    localparam int QUO_BITS    = 15;
    localparam int CNT_W       = $clog2(QUO_BITS);
    // busy * 25 needs 5 extra bits; numerator = busy * 25 << 10
    localparam int MUL_W       = TICK_W + 5;
    localparam int FS_SHIFT    = 10;

    localparam logic [PCT_W-1:0] FULL_SCALE = PCT_W'(25600);

    typedef struct packed {
        logic [IDX_W-1:0]  entry_index;
        logic [TICK_W-1:0] user_ticks;
        logic [TICK_W-1:0] nice_ticks;
        logic [TICK_W-1:0] system_ticks;
        logic [TICK_W-1:0] idle_ticks;
        logic [TICK_W-1:0] iowait_ticks;
        logic [TICK_W-1:0] irq_ticks;
        logic [TICK_W-1:0] softirq_ticks;
        logic [TICK_W-1:0] steal_ticks;
    } snap_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        logic [PCT_W-1:0] busy_percent;
        logic             result_valid;
    } result_t;

    typedef struct packed {
        logic             load;
        logic             sum_step;
        logic [SEL_W-1:0] sum_sel;
        logic             fetch;
        logic             delta;
        logic             decide;
        logic             mul_a;
        logic             mul_b;
        logic             div_step;
        logic             round;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic early;   // no division needed: baseline only, ignored, or zero result
    } dp_status_t;

endpackage

### rtl/cpuu_dp.sv
// Datapath: snapshot registers, baseline store, delta, scale, restoring divide, rounding and output register.
module cpuu_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpuu_pkg::snap_t      snap,
    input  cpuu_pkg::dp_cmd_t    cmd,
    output cpuu_pkg::dp_status_t status,
    output cpuu_pkg::result_t    res
);

    logic [cpuu_pkg::IDX_W-1:0]    idx_reg;
    logic [cpuu_pkg::TICK_W-1:0]   ticks_reg [cpuu_pkg::COUNTER_NUM];
    logic [cpuu_pkg::TICK_W-1:0]   total_reg;
    logic [cpuu_pkg::TICK_W-1:0]   idle_reg;
    logic [2*cpuu_pkg::TICK_W-1:0] prev_rd_reg;
    logic [cpuu_pkg::TICK_W-1:0]   dt_reg;
    logic [cpuu_pkg::TICK_W-1:0]   di_reg;
    logic [cpuu_pkg::TICK_W-1:0]   busy_reg;
    logic [cpuu_pkg::MUL_W-1:0]    prod_reg;
    logic [cpuu_pkg::TICK_W-1:0]   rem_reg;
    logic [cpuu_pkg::QUO_BITS-1:0] nlo_reg;
    logic [cpuu_pkg::QUO_BITS-1:0] quo_reg;
    logic [cpuu_pkg::PCT_W-1:0]    pct_reg;
    logic                          vld_reg;
    cpuu_pkg::result_t             res_reg;
    logic [cpuu_pkg::ENTRY_COUNT-1:0] seen_reg;

    // {total, idle} per entry
    logic [2*cpuu_pkg::TICK_W-1:0] prev_mem [cpuu_pkg::ENTRY_COUNT];

    logic                          in_range;
    logic [cpuu_pkg::ENTRY_AW-1:0] addr;
    logic [cpuu_pkg::MUL_W-1:0]    prod_sum;
    logic [cpuu_pkg::TICK_W:0]     div_r2;
    logic [cpuu_pkg::TICK_W+1:0]   div_diff;
    logic                          div_ge;
    logic [cpuu_pkg::TICK_W:0]     rem_twice;
    logic                          round_up;
    logic [cpuu_pkg::PCT_W:0]      quo_rounded;

    assign in_range = idx_reg <= cpuu_pkg::IDX_W'(cpuu_pkg::MAX_CORES);
    assign addr     = in_range ? idx_reg[cpuu_pkg::ENTRY_AW-1:0] : '0;

    assign prod_sum = prod_reg + cpuu_pkg::MUL_W'(busy_reg);

    assign div_r2   = {rem_reg, nlo_reg[cpuu_pkg::QUO_BITS-1]};
    assign div_diff = {1'b0, div_r2} - {2'b00, dt_reg};
    assign div_ge   = !div_diff[cpuu_pkg::TICK_W+1];

    // round half up: remainder at least half the divisor
    assign rem_twice   = {rem_reg, 1'b0};
    assign round_up    = rem_twice >= {1'b0, dt_reg};
    assign quo_rounded = {1'b0, quo_reg} + (cpuu_pkg::PCT_W+1)'(round_up);

    assign status.early = !in_range || !seen_reg[addr] || (dt_reg == '0)
                          || (di_reg > dt_reg);

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (cmd.decide && in_range)
        begin
            seen_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide && in_range)
        begin
            prev_mem[addr] <= {total_reg, idle_reg};
        end
        if (cmd.fetch)
        begin
            prev_rd_reg <= prev_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg      <= snap.entry_index;
            ticks_reg[0] <= snap.user_ticks;
            ticks_reg[1] <= snap.nice_ticks;
            ticks_reg[2] <= snap.system_ticks;
            ticks_reg[3] <= snap.idle_ticks;
            ticks_reg[4] <= snap.iowait_ticks;
            ticks_reg[5] <= snap.irq_ticks;
            ticks_reg[6] <= snap.softirq_ticks;
            ticks_reg[7] <= snap.steal_ticks;
        end
        if (cmd.sum_step)
        begin
            if (cmd.sum_sel == '0)
            begin
                total_reg <= ticks_reg[0];
                idle_reg  <= ticks_reg[3] + ticks_reg[4];
            end
            else
            begin
                total_reg <= total_reg + ticks_reg[cmd.sum_sel];
            end
        end
        if (cmd.delta)
        begin
            dt_reg <= total_reg - prev_rd_reg[2*cpuu_pkg::TICK_W-1:cpuu_pkg::TICK_W];
            di_reg <= idle_reg - prev_rd_reg[cpuu_pkg::TICK_W-1:0];
        end
        if (cmd.decide)
        begin
            busy_reg <= dt_reg - di_reg;
            vld_reg  <= in_range && seen_reg[addr];
            pct_reg  <= '0;
        end
        if (cmd.mul_a)
        begin
            // busy * 24
            prod_reg <= {1'b0, busy_reg, 4'b0000} + {2'b00, busy_reg, 3'b000};
        end
        if (cmd.mul_b)
        begin
            // busy * 25; numerator is this shifted up by 10
            rem_reg <= prod_sum[cpuu_pkg::MUL_W-1:cpuu_pkg::QUO_BITS-cpuu_pkg::FS_SHIFT];
            nlo_reg <= {prod_sum[cpuu_pkg::QUO_BITS-cpuu_pkg::FS_SHIFT-1:0],
                        cpuu_pkg::FS_SHIFT'(0)};
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[cpuu_pkg::TICK_W-1:0]
                              : div_r2[cpuu_pkg::TICK_W-1:0];
            nlo_reg <= {nlo_reg[cpuu_pkg::QUO_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[cpuu_pkg::QUO_BITS-2:0], div_ge};
        end
        if (cmd.round)
        begin
            pct_reg <= (quo_rounded > {1'b0, cpuu_pkg::FULL_SCALE})
                       ? cpuu_pkg::FULL_SCALE : quo_rounded[cpuu_pkg::PCT_W-1:0];
        end
        if (cmd.out_load)
        begin
            res_reg.result_index <= idx_reg;
            res_reg.busy_percent <= pct_reg;
            res_reg.result_valid <= vld_reg;
        end
    end

endmodule

### rtl/cpuu_ctrl.sv
// Controller: sequences one request through the datapath and owns the result valid.
module cpuu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 snap_valid,
    output logic                 snap_stall,
    output logic                 res_valid,
    input  logic                 res_stall,
    input  cpuu_pkg::dp_status_t status,
    output cpuu_pkg::dp_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SUM    = 4'd1;
    localparam logic [3:0] S_DELTA  = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_MUL_A  = 4'd4;
    localparam logic [3:0] S_MUL_B  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_ROUND  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]               state_reg, state_next;
    logic [cpuu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     res_valid_reg, res_valid_next;

    assign snap_stall = state_reg != S_IDLE;
    assign res_valid  = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (snap_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                cmd.sum_sel  = cnt_reg[cpuu_pkg::SEL_W-1:0];
                cmd.fetch    = 1'b1;
                if (cnt_reg == cpuu_pkg::CNT_W'(cpuu_pkg::COUNTER_NUM - 1))
                begin
                    state_next = S_DELTA;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.early ? S_DONE : S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == cpuu_pkg::CNT_W'(cpuu_pkg::QUO_BITS - 1))
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.out_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/cpu_utilization_from_tick_counters.sv
// Top level of the CPU busy-percentage meter over cumulative tick counters.
// Input channel snap (snap_valid / snap_stall): one snapshot of eight tick
// counters for an entry; entries 0..15 are cores, 16 is the aggregate.
// Output channel res (res_valid / res_stall): one result per request with the
// entry index, busy percent in Q7.8 (25600 = 100.0) and a valid flag; the flag
// is 0 on an entry's first sample or for an index above 16.
// Timing: one request at a time. The 64-bit total is summed one counter per
// cycle, then the delta and the decision follow. A request that needs a divide
// adds shift-add scaling, a restoring divider (one quotient bit per cycle) and
// a rounding step before the result is loaded into the output register; a
// request without a divide goes there straight after the decision. The
// controller returns to idle before it takes the next request.
// The result sits in its own register, so a new request is accepted while the
// previous result is still stalled; a finished request waits only if the
// output register is still held by res_stall.
// Reset clears the controller and the per-entry baseline flags; stored
// baselines are not cleared, every entry starts with a baseline sample.
`include "cpu_utilization_from_tick_counters_macros.svh"

module cpu_utilization_from_tick_counters (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              snap_valid,
    output logic              snap_stall,
    input  cpuu_pkg::snap_t   snap,
    output logic              res_valid,
    input  logic              res_stall,
    output cpuu_pkg::result_t res
);

    cpuu_pkg::dp_cmd_t    cmd;
    cpuu_pkg::dp_status_t status;

    cpuu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_stall (snap_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .cmd        (cmd)
    );

    cpuu_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .snap   (snap),
        .cmd    (cmd),
        .status (status),
        .res    (res)
    );

    `CPUU_ASSERT_NEXT(a_busy_after_accept, snap_valid && !snap_stall, snap_stall, "request accepted but input not stalled next cycle")
    `CPUU_ASSERT_NOW(a_invalid_is_zero, res_valid && !res.result_valid, res.busy_percent == '0, "invalid result with nonzero percent")
    `CPUU_ASSERT_NOW(a_full_scale, res_valid, res.busy_percent <= cpuu_pkg::FULL_SCALE, "percent above full scale")

endmodule
